### sv/vegf_pkg.sv
// ----------------------------------------------------------------------------
// vegf_pkg
// Shared types, command codes and GF(2^16) helpers for the Vandermonde
// erasure encoder (x^16+x^12+x^3+x+1, alpha = 2).
// ----------------------------------------------------------------------------
package vegf_pkg;

	typedef logic [15:0] word_t;

	localparam logic [16:0] POLY_FULL = 17'h1100B;

	typedef enum logic [1:0] {
		CMD_ADD_WORD = 2'd0,
		CMD_ADD_LEN  = 2'd1,
		CMD_READ_WORD = 2'd2,
		CMD_READ_LEN = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_ADD,
		S_RDREQ,
		S_RDDATA,
		S_RDOUT
	} state_t;

	// carry-less product, then reduction of the upper fifteen bits
	function automatic word_t gf_mul(input word_t a, input word_t b);
		logic [30:0] prod;
		prod = '0;
		for (int k = 0; k < 16; k++) begin
			if (b[k]) begin
				prod = prod ^ (31'(a) << k);
			end
		end
		for (int k = 30; k >= 16; k--) begin
			if (prod[k]) begin
				prod = prod ^ (31'(POLY_FULL) << (k - 16));
			end
		end
		return prod[15:0];
	endfunction

	// elaboration only: alpha^e by repeated doubling
	function automatic word_t alpha_pow(input int e);
		word_t r;
		r = 16'd1;
		for (int k = 0; k < e; k++) begin
			r = gf_mul(r, 16'd2);
		end
		return r;
	endfunction

endpackage

### sv/vegf_if.sv
// ----------------------------------------------------------------------------
// vegf channel interfaces
// Command, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface vegf_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [4:0]  packet_index;
	logic [3:0]  repair_index;
	logic [9:0]  word_offset;
	logic [15:0] value;

	modport source (output valid, command, packet_index, repair_index, word_offset, value,
		input ready);
	modport sink (input valid, command, packet_index, repair_index, word_offset, value,
		output ready);
endinterface

interface vegf_res_if;
	logic        valid;
	logic        ready;
	logic [15:0] read_value;

	modport source (output valid, read_value, input ready);
	modport sink (input valid, read_value, output ready);
endinterface

interface vegf_cfg_if;
	logic       valid;
	logic       ready;
	logic [4:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

### sv/vegf_ram.sv
// ----------------------------------------------------------------------------
// vegf_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module vegf_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### sv/vandermonde_erasure_encoder_gf16_core.sv
// ----------------------------------------------------------------------------
// vandermonde_erasure_encoder_gf16_core
// Accumulates Vandermonde repair words and repair lengths over GF(2^16).
// ----------------------------------------------------------------------------
// Channels: cmd takes one command beat (add word, add length, read word,
// read length); res returns one beat per read command; cfg writes
// repair_count at any time, always ready.
// After reset the block sweeps zero through the word store and the length
// store, one entry a cycle, 2**(clog2(REPAIR_MAX)+clog2(WORDS_MAX)) entries
// of the word store (16384 at the defaults); cmd.ready stays low meanwhile.
// An add beat, n = active repair count, runs in S_ADD after acceptance:
// one shared GF multiplier steps the coefficient alpha^(i*j) once per
// repair while the store is read one repair ahead and written back.
// Invalid adds go straight back to idle. A read passes after acceptance
// through address, read data and clear, and output load to reach the output
// register; an invalid read goes straight to output load and returns zero.
// The block takes one command at a time; cmd.ready is high only when idle.
// The result sits in an output register; a stalled receiver holds it there,
// and a following read stalls in its last step until the register is free.
// ----------------------------------------------------------------------------
module vandermonde_erasure_encoder_gf16_core #(
	parameter int DATA_PACKETS_MAX = 32,
	parameter int REPAIR_MAX = 16,
	parameter int WORDS_MAX = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	vegf_cmd_if.sink   cmd,
	vegf_res_if.source res,
	vegf_cfg_if.sink   cfg
);

	localparam int PKT_W = $clog2(DATA_PACKETS_MAX);
	localparam int REP_W = (REPAIR_MAX > 1) ? $clog2(REPAIR_MAX) : 1;
	localparam int CNT_W = $clog2(REPAIR_MAX + 1);
	localparam int OFF_W = $clog2(WORDS_MAX);
	localparam int ADDR_W = REP_W + OFF_W;

	vegf_pkg::state_t state_q, state_d;

	logic [4:0]        count_q;
	logic [CNT_W-1:0]  act_n;
	logic [CNT_W-1:0]  n_q;
	logic [CNT_W-1:0]  rj_q;
	logic [REP_W-1:0]  wj_q;
	logic              wv_q;
	logic              is_len_q;
	logic [REP_W-1:0]  rep_q;
	logic [OFF_W-1:0]  off_q;
	vegf_pkg::word_t   p_q;
	vegf_pkg::word_t   a_q;
	vegf_pkg::word_t   res_q;
	logic [ADDR_W-1:0] clr_q;
	logic              out_valid_q;
	vegf_pkg::word_t   out_data_q;

	vegf_pkg::word_t   alpha_tbl [DATA_PACKETS_MAX];

	logic              accept;
	logic              load_out;
	logic              pkt_ok, rep_ok, off_ok, add_ok, rd_ok;
	logic              cmd_is_add, cmd_is_len;
	logic [REP_W-1:0]  rd_rep;
	logic              w_we, l_we;
	logic [ADDR_W-1:0] w_waddr;
	logic [REP_W-1:0]  l_waddr;
	vegf_pkg::word_t   wdata;
	vegf_pkg::word_t   w_rdata, l_rdata, rdata_sel;

	for (genvar g = 0; g < DATA_PACKETS_MAX; g++) begin : g_alpha
		assign alpha_tbl[g] = vegf_pkg::alpha_pow(g);
	end

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 5'd1;
		end else if (cfg.valid) begin
			count_q <= cfg.data;
		end
	end

	assign act_n = (32'(count_q) > REPAIR_MAX) ? CNT_W'(REPAIR_MAX) : CNT_W'(count_q);

	// command decode
	assign cmd.ready = (state_q == vegf_pkg::S_IDLE);
	assign accept = cmd.valid && cmd.ready;

	assign pkt_ok = 32'(cmd.packet_index) < DATA_PACKETS_MAX;
	assign rep_ok = 32'(cmd.repair_index) < REPAIR_MAX;
	assign off_ok = 32'(cmd.word_offset) < WORDS_MAX;

	always_comb begin
		unique case (vegf_pkg::cmd_t'(cmd.command))
			vegf_pkg::CMD_ADD_WORD: begin
				cmd_is_add = 1'b1;
				cmd_is_len = 1'b0;
			end
			vegf_pkg::CMD_ADD_LEN: begin
				cmd_is_add = 1'b1;
				cmd_is_len = 1'b1;
			end
			vegf_pkg::CMD_READ_WORD: begin
				cmd_is_add = 1'b0;
				cmd_is_len = 1'b0;
			end
			vegf_pkg::CMD_READ_LEN: begin
				cmd_is_add = 1'b0;
				cmd_is_len = 1'b1;
			end
			default: begin
				cmd_is_add = 1'b0;
				cmd_is_len = 1'b0;
			end
		endcase
	end

	assign add_ok = pkt_ok && (cmd_is_len || off_ok) && (act_n != '0);
	assign rd_ok = rep_ok && (cmd_is_len || off_ok);

	assign load_out = (state_q == vegf_pkg::S_RDOUT) && (!out_valid_q || res.ready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= vegf_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		w_we = 1'b0;
		l_we = 1'b0;
		w_waddr = {rep_q, off_q};
		l_waddr = rep_q;
		wdata = '0;
		rd_rep = rep_q;
		unique case (state_q)
			vegf_pkg::S_CLEAR: begin
				w_we = 1'b1;
				l_we = 1'b1;
				w_waddr = clr_q;
				l_waddr = clr_q[REP_W-1:0];
				if (&clr_q) begin
					state_d = vegf_pkg::S_IDLE;
				end
			end
			vegf_pkg::S_IDLE: begin
				if (accept) begin
					if (cmd_is_add) begin
						state_d = add_ok ? vegf_pkg::S_ADD : vegf_pkg::S_IDLE;
					end else begin
						state_d = rd_ok ? vegf_pkg::S_RDREQ : vegf_pkg::S_RDOUT;
					end
				end
			end
			vegf_pkg::S_ADD: begin
				rd_rep = REP_W'(rj_q);
				w_waddr = {wj_q, off_q};
				l_waddr = wj_q;
				wdata = rdata_sel ^ p_q;
				w_we = wv_q && !is_len_q;
				l_we = wv_q && is_len_q;
				if (rj_q == n_q) begin
					state_d = vegf_pkg::S_IDLE;
				end
			end
			vegf_pkg::S_RDREQ: begin
				state_d = vegf_pkg::S_RDDATA;
			end
			vegf_pkg::S_RDDATA: begin
				w_we = !is_len_q;
				l_we = is_len_q;
				state_d = vegf_pkg::S_RDOUT;
			end
			vegf_pkg::S_RDOUT: begin
				if (load_out) begin
					state_d = vegf_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = vegf_pkg::S_IDLE;
			end
		endcase
	end

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			rj_q <= '0;
			wv_q <= 1'b0;
		end else begin
			if (state_q == vegf_pkg::S_CLEAR) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (accept) begin
				rj_q <= '0;
				wv_q <= 1'b0;
			end else if (state_q == vegf_pkg::S_ADD) begin
				if (rj_q != n_q) begin
					rj_q <= rj_q + CNT_W'(1);
					wv_q <= 1'b1;
				end else begin
					wv_q <= 1'b0;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			is_len_q <= cmd_is_len;
			rep_q <= REP_W'(cmd.repair_index);
			off_q <= OFF_W'(cmd.word_offset);
			p_q <= cmd.value;
			a_q <= alpha_tbl[PKT_W'(cmd.packet_index)];
			n_q <= act_n;
			res_q <= '0;
		end else begin
			if (state_q == vegf_pkg::S_ADD) begin
				if (rj_q != n_q) begin
					wj_q <= REP_W'(rj_q);
				end
				if (wv_q) begin
					p_q <= vegf_pkg::gf_mul(p_q, a_q);
				end
			end
			if (state_q == vegf_pkg::S_RDDATA) begin
				res_q <= rdata_sel;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= res_q;
		end
	end

	assign res.valid = out_valid_q;
	assign res.read_value = out_data_q;

	// stores
	vegf_ram #(
		.WIDTH (16),
		.DEPTH (2 ** ADDR_W)
	) u_word_ram (
		.clk   (clk),
		.we    (w_we),
		.waddr (w_waddr),
		.wdata (wdata),
		.raddr ({rd_rep, off_q}),
		.rdata (w_rdata)
	);

	vegf_ram #(
		.WIDTH (16),
		.DEPTH (2 ** REP_W)
	) u_len_ram (
		.clk   (clk),
		.we    (l_we),
		.waddr (l_waddr),
		.wdata (wdata),
		.raddr (rd_rep),
		.rdata (l_rdata)
	);

	assign rdata_sel = is_len_q ? l_rdata : w_rdata;

	// checks
	a_add_n_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == vegf_pkg::S_ADD |-> n_q != '0)
		else $error("add sequence running with zero repairs");

	a_add_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == vegf_pkg::S_ADD |-> rj_q <= n_q)
		else $error("repair index ran past active count");

	a_add_last_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == vegf_pkg::S_ADD && rj_q == n_q) |-> wv_q)
		else $error("add sequence ends without final write-back");

	a_add_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == vegf_pkg::S_ADD && wv_q && rj_q != n_q) |-> wj_q != REP_W'(rj_q))
		else $error("read and write-back hit the same repair");

	a_out_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == vegf_pkg::S_RDOUT)
		else $error("result beat without a read command");

endmodule
